// ===== rtl/gshare_fsm_branch_predictor_macros.svh =====
// Assertion macros used by the predictor checker.
`ifndef GSHARE_FSM_BRANCH_PREDICTOR_MACROS_SVH
`define GSHARE_FSM_BRANCH_PREDICTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define GFBP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define GFBP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/gfbp_pkg.sv =====
// Types, constants and helpers for the gshare FSM branch predictor.
package gfbp_pkg;

   localparam int STATE_W = 3;
   localparam int TRANS_W = 24;
   localparam int COUNT_W = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [TRANS_W-1:0] TAKEN_RESET     = 24'd13819846;
   localparam logic [TRANS_W-1:0] NOT_TAKEN_RESET = 24'd7218185;

   typedef logic [STATE_W-1:0] entry_type;
   typedef logic [TRANS_W-1:0] trans_type;

   typedef enum logic {
      REG_TAKEN     = 1'b0,
      REG_NOT_TAKEN = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_CLEAR = 2'b01,
      ST_RUN   = 2'b10
   } state_type;

   // Pick the 3-bit next state for the current entry out of a packed table.
   function automatic entry_type next_state(input trans_type tbl, input entry_type cur);
      return tbl[cur*STATE_W +: STATE_W];
   endfunction

endpackage

// ===== rtl/gshare_fsm_branch_predictor.sv =====
// Gshare branch predictor with 3-bit pattern entries driven by configurable FSM tables.
//
// Usage:
//   Request channel: drive req_branch_addr_low and req_taken with start high; the
//   request is taken at a rising edge where start is high and busy is low.
//   Result channel: rsp_valid is high for exactly one cycle with the prediction,
//   the hit flag and both running counts. The receiver cannot stall it.
//   Pipeline: the request edge reads the table and loads the stage 1 registers;
//   the update and result registers follow, and then the result is on the ports.
//   Throughput: one request per cycle while busy is low; the table is read
//   ahead of its write, and the entry written by the previous request is
//   forwarded when both hit the same entry.
//   Configuration: APB-style port, taken table at byte 0, not-taken table at
//   byte 4; write only while idle. pready is always high.
//   Reset: synchronous, active high. It clears history, counters and the tables
//   to their defaults, then a clearing pass zeroes the pattern table one entry a
//   cycle across all 2**INDEX_BITS entries, with busy high; configuration writes
//   are still taken during the pass.
module gshare_fsm_branch_predictor
   import gfbp_pkg::*;
#(
   parameter int INDEX_BITS = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [6:0]            req_branch_addr_low,
   input  logic                  req_taken,
   output logic                  rsp_valid,
   output logic                  rsp_predicted_taken,
   output logic                  rsp_hit,
   output logic [COUNT_W-1:0]    rsp_branch_count,
   output logic [COUNT_W-1:0]    rsp_hit_count,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int DEPTH = 1 << INDEX_BITS;

   typedef logic [INDEX_BITS-1:0] index_type;

   entry_type pattern_mem [DEPTH];

   state_type     state_ff, state_in;
   index_type     clr_idx_ff, clr_idx_in;
   index_type     hist_ff, hist_in;
   trans_type     taken_tbl_ff, taken_tbl_in;
   trans_type     not_taken_tbl_ff, not_taken_tbl_in;
   logic          s1_valid_ff;
   index_type     s1_idx_ff;
   logic          s1_taken_ff;
   logic          fwd_ff, fwd_in;
   entry_type     fwd_state_ff;
   entry_type     mem_rd_ff;
   logic          rsp_valid_ff;
   logic          rsp_pred_ff, rsp_pred_in;
   logic          rsp_hit_ff, rsp_hit_in;
   logic [COUNT_W-1:0] branch_cnt_ff, branch_cnt_in;
   logic [COUNT_W-1:0] hit_cnt_ff, hit_cnt_in;

   logic          accept;
   logic          csr_write;
   reg_index_type csr_sel;
   index_type     idx_in;
   entry_type     cur_state;
   entry_type     upd_state;

   assign busy      = (state_ff != ST_RUN);
   assign accept    = start && !busy;
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_sel   = reg_index_type'(paddr[2]);

   // Address bits 6..1 are zero-extended or cut to the table index width.
   assign idx_in  = INDEX_BITS'(req_branch_addr_low[6:1]) ^ hist_ff;
   assign hist_in = accept ? {hist_ff[INDEX_BITS-2:0], req_taken} : hist_ff;
   assign fwd_in  = s1_valid_ff && (s1_idx_ff == idx_in);

   // Stage 1: take the forwarded entry when the previous request wrote it.
   assign cur_state   = fwd_ff ? fwd_state_ff : mem_rd_ff;
   assign rsp_pred_in = cur_state[2] ^ cur_state[1];
   assign rsp_hit_in  = (rsp_pred_in == s1_taken_ff);
   assign upd_state   = next_state(s1_taken_ff ? taken_tbl_ff : not_taken_tbl_ff, cur_state);

   always_comb begin
      branch_cnt_in = branch_cnt_ff;
      hit_cnt_in    = hit_cnt_ff;
      if (s1_valid_ff) begin
         branch_cnt_in = branch_cnt_ff + 1'b1;
         hit_cnt_in    = hit_cnt_ff + COUNT_W'(rsp_hit_in);
      end
   end

   always_comb begin
      state_in   = state_ff;
      clr_idx_in = clr_idx_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == index_type'(DEPTH - 1)) state_in = ST_RUN;
         end
         ST_RUN: begin
            clr_idx_in = clr_idx_ff;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      taken_tbl_in     = taken_tbl_ff;
      not_taken_tbl_in = not_taken_tbl_ff;
      if (csr_write) begin
         unique case (csr_sel)
            REG_TAKEN:     taken_tbl_in     = pwdata[TRANS_W-1:0];
            REG_NOT_TAKEN: not_taken_tbl_in = pwdata[TRANS_W-1:0];
            default:       taken_tbl_in     = taken_tbl_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         REG_TAKEN:     prdata = CSR_DATA_W'(taken_tbl_ff);
         REG_NOT_TAKEN: prdata = CSR_DATA_W'(not_taken_tbl_ff);
         default:       prdata = '0;
      endcase
   end

   // Pattern table: one write port (clear or update), one registered read port.
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         pattern_mem[clr_idx_ff] <= '0;
      end else if (s1_valid_ff) begin
         pattern_mem[s1_idx_ff] <= upd_state;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mem_rd_ff <= pattern_mem[idx_in];
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_idx_ff    <= idx_in;
         s1_taken_ff  <= req_taken;
         fwd_ff       <= fwd_in;
         fwd_state_ff <= upd_state;
      end
      if (s1_valid_ff) begin
         rsp_pred_ff <= rsp_pred_in;
         rsp_hit_ff  <= rsp_hit_in;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         clr_idx_ff       <= '0;
         hist_ff          <= '0;
         taken_tbl_ff     <= TAKEN_RESET;
         not_taken_tbl_ff <= NOT_TAKEN_RESET;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         branch_cnt_ff    <= '0;
         hit_cnt_ff       <= '0;
      end else begin
         state_ff         <= state_in;
         clr_idx_ff       <= clr_idx_in;
         hist_ff          <= hist_in;
         taken_tbl_ff     <= taken_tbl_in;
         not_taken_tbl_ff <= not_taken_tbl_in;
         s1_valid_ff      <= accept;
         rsp_valid_ff     <= s1_valid_ff;
         branch_cnt_ff    <= branch_cnt_in;
         hit_cnt_ff       <= hit_cnt_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_predicted_taken = rsp_pred_ff;
   assign rsp_hit             = rsp_hit_ff;
   assign rsp_branch_count    = branch_cnt_ff;
   assign rsp_hit_count       = hit_cnt_ff;

endmodule

// ===== rtl/gfbp_checker.sv =====
// Port-level checker for the gshare FSM branch predictor, bound to the top level.
`include "gshare_fsm_branch_predictor_macros.svh"

module gfbp_checker
   import gfbp_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  req_taken,
   input logic                  rsp_valid,
   input logic                  rsp_predicted_taken,
   input logic                  rsp_hit,
   input logic [COUNT_W-1:0]    rsp_branch_count,
   input logic [COUNT_W-1:0]    rsp_hit_count
);

   // Every accepted request yields exactly one result, once it has passed the stage 1 and result registers.
   `GFBP_ASSERT_NOW(a_req_to_rsp, clock, reset, start && !busy, ##2 rsp_valid, "request lost")
   `GFBP_ASSERT_NOW(a_rsp_from_req, clock, reset, rsp_valid, $past(start && !busy, 2), "result invented")

   // Hit flag must agree with the prediction and the outcome of the matching request.
   `GFBP_ASSERT_NOW(a_hit_match, clock, reset, rsp_valid,
      rsp_hit == (rsp_predicted_taken == $past(req_taken, 2)), "hit flag wrong")

   // Back-to-back results advance the branch count by one and the hit count by the hit flag.
   `GFBP_ASSERT_NOW(a_count_step, clock, reset, rsp_valid && $past(rsp_valid),
      (rsp_branch_count == $past(rsp_branch_count) + 32'd1) &&
      (rsp_hit_count == $past(rsp_hit_count) + COUNT_W'(rsp_hit)), "count step wrong")

   // The clearing pass holds requests off right after reset.
   `GFBP_ASSERT_NOW(a_busy_after_reset, clock, reset, $fell(reset), busy, "not busy after reset")

endmodule

bind gshare_fsm_branch_predictor gfbp_checker u_gfbp_checker (.*);
